FILE: sv/plid_pkg.sv
// package for the positional list insert/delete core
// holds list sizing, operation and status codes, the entry type and the cell control struct
`default_nettype none

package plid_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 7;
  localparam int unsigned SCORE_W  = 64;
  localparam int unsigned TOTAL_W  = 7;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               flag;
  } entry_t;

  // broadcast to every cell for one request
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [IDX_W-1:0] idx;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/positional_list_insert_delete_core.sv
// top level of the positional list insert/delete core
// depends on plid_pkg and plid_cell; one chain of CAPACITY cells plus count and result register
//
// usage:
//   requests enter on the s_axis group: kind in tuser, position, score and flag in tdata.
//   a request is taken when s_axis_tvalid and s_axis_tready are both high.
//   each request gives exactly one result on the m_axis group: status in tuser,
//   score, flag and the entry count after the operation in tdata.
// latency and throughput:
//   the result is registered and appears the cycle after the request is taken.
//   every cell of the chain shifts at once, and a new request is taken every
//   cycle while results are drained.
// reset:
//   rst_ni clears the entry count and the output valid; cell contents are not
//   cleared, since only positions below the count are ever read.
// stall:
//   while m_axis_tready is low and a result waits, s_axis_tready drops and the
//   list holds; nothing is lost or repeated.
`default_nettype none

module positional_list_insert_delete_core
  import plid_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // position[6:0], entry_score[70:7], entry_flag[71]
  input  wire logic [1:0]  s_axis_tuser,  // kind[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // out_score[63:0], out_flag[64], item_total[71:65]
  output logic [1:0]       m_axis_tuser   // status[1:0]
);

  localparam int unsigned CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  kind_e            kind;
  logic [POS_W-1:0] position;
  entry_t           new_entry;

  logic             s_fire;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CMP_W-1:0] pos_x, cnt_x;
  logic             ins_ok, rd_ok;
  logic             full;
  status_e          status_d;
  cell_ctrl_t       ctrl;
  entry_t           rd_sel, res_d;

  logic             out_valid_q;
  status_e          status_q;
  entry_t           res_q;
  logic [CNT_W-1:0] total_q;

  entry_t cell_q  [CAPACITY];
  entry_t cell_rd [CAPACITY];

  assign kind            = kind_e'(s_axis_tuser);
  assign position        = s_axis_tdata[POS_W-1:0];
  assign new_entry.score = s_axis_tdata[POS_W+SCORE_W-1:POS_W];
  assign new_entry.flag  = s_axis_tdata[POS_W+SCORE_W];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign pos_x  = CMP_W'(position);
  assign cnt_x  = CMP_W'(cnt_q);
  assign full   = (cnt_q == CNT_W'(CAPACITY));
  assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign rd_ok  = (pos_x != '0) && (pos_x <= cnt_x);

  always_comb begin
    status_d = ST_RANGE;
    ctrl.ins = 1'b0;
    ctrl.del = 1'b0;
    ctrl.idx = IDX_W'(position - POS_W'(1));
    res_d    = '0;
    cnt_d    = cnt_q;
    unique case (kind)
      KIND_INSERT: begin
        if (ins_ok) begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            status_d = ST_OK;
            ctrl.ins = s_fire;
            cnt_d    = cnt_q + CNT_W'(1);
          end
        end
      end
      KIND_DELETE: begin
        if (rd_ok) begin
          status_d = ST_OK;
          ctrl.del = s_fire;
          res_d    = rd_sel;
          cnt_d    = cnt_q - CNT_W'(1);
        end
      end
      KIND_READ: begin
        if (rd_ok) begin
          status_d = ST_OK;
          res_d    = rd_sel;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  // chain of cells, each tied to its neighbors
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t left_n, right_n;
    if (g == 0) begin : g_first
      assign left_n = '0;
    end else begin : g_mid_l
      assign left_n = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_n = '0;
    end else begin : g_mid_r
      assign right_n = cell_q[g+1];
    end
    plid_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .cell_idx_i (IDX_W'(g)),
      .left_i     (left_n),
      .right_i    (right_n),
      .new_i      (new_entry),
      .entry_o    (cell_q[g]),
      .rd_o       (cell_rd[g])
    );
  end

  // only the addressed cell drives a nonzero read value
  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_fire) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      status_q <= status_d;
      res_q    <= res_d;
      total_q  <= cnt_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {TOTAL_W'(total_q), res_q.flag, res_q.score};

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && ctrl.ins |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_del_shrink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && ctrl.del |=> cnt_q == $past(cnt_q) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_full_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_FULL |-> total_q == CNT_W'(CAPACITY))
    else $error("full status with list not full");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |-> res_q == '0)
    else $error("error result carries payload");

endmodule

`default_nettype wire

FILE: sv/plid_cell.sv
// one storage cell of the positional list chain
// depends on plid_pkg; shifts from its left or right neighbor or loads a new entry
`default_nettype none

module plid_cell
  import plid_pkg::*;
(
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [IDX_W-1:0] cell_idx_i,
  input  wire entry_t           left_i,
  input  wire entry_t           right_i,
  input  wire entry_t           new_i,
  output entry_t                entry_o,
  output entry_t                rd_o
);

  entry_t entry_q, entry_d;
  logic   hit, above;

  assign hit   = (cell_idx_i == ctrl_i.idx);
  assign above = (cell_idx_i > ctrl_i.idx);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (hit) begin
        entry_d = new_i;
      end else if (above) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.del) begin
      // cells at and after the removed place pull from the right
      if (hit || above) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign rd_o    = hit ? entry_q : '0;

endmodule

`default_nettype wire
